// ===== src/edvf_pkg.sv =====
// Shared types and constants of the edge depth visibility filter.
// No dependencies; compile first.
package edvf_pkg;

  typedef logic signed [16:0] lane_t;

  typedef struct packed {
    logic         valid;
    logic         last;
    lane_t [2:0]  val;
  } smp_t;

  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;

  localparam logic [1:0] OP_WRITE_DEPTH  = 2'd0;
  localparam logic [1:0] OP_WRITE_VERTEX = 2'd1;
  localparam logic [1:0] OP_TEST_EDGE    = 2'd2;

  localparam logic [1:0] STATUS_VISIBLE    = 2'd0;
  localparam logic [1:0] STATUS_HIDDEN     = 2'd1;
  localparam logic [1:0] STATUS_BAD_INDEX  = 2'd2;
  localparam logic [1:0] STATUS_OFF_SCREEN = 2'd3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_EPSILON = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VISIBLE   = 3'd4;

  localparam logic [8:0]  SCREEN_WIDTH_RST  = 9'd256;
  localparam logic [8:0]  SCREEN_HEIGHT_RST = 9'd256;
  localparam logic [8:0]  VERTEX_COUNT_RST  = 9'd0;
  localparam logic [15:0] DEPTH_EPSILON_RST = 16'd0;
  localparam logic [4:0]  MIN_VISIBLE_RST   = 5'd11;

endpackage

// ===== src/edvf_if.sv =====
// Valid/ready channels of the edge depth visibility filter: request and result beats.
// No dependencies.
interface edvf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [7:0]         pixel_x;
  logic [7:0]         pixel_y;
  logic [15:0]        pixel_depth;
  logic [7:0]         vert_slot;
  logic signed [15:0] vert_x;
  logic signed [15:0] vert_y;
  logic [15:0]        vert_z;
  logic [9:0]         edge_first;
  logic [9:0]         edge_second;

  modport source (output valid, opcode, pixel_x, pixel_y, pixel_depth, vert_slot,
                  vert_x, vert_y, vert_z, edge_first, edge_second, input ready);
  modport sink   (input valid, opcode, pixel_x, pixel_y, pixel_depth, vert_slot,
                  vert_x, vert_y, vert_z, edge_first, edge_second, output ready);
endinterface

interface edvf_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [4:0]         visible_samples;
  logic signed [15:0] line_x1;
  logic signed [15:0] line_y1;
  logic signed [15:0] line_x2;
  logic signed [15:0] line_y2;

  modport source (output valid, status, visible_samples, line_x1, line_y1, line_x2,
                  line_y2, input ready);
  modport sink   (input valid, status, visible_samples, line_x1, line_y1, line_x2,
                  line_y2, output ready);
endinterface

// ===== src/edvf_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module edvf_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/edvf_stepper.sv =====
// Sample generator: from + trunc(i*(to-from)/SAMPLE_STEPS) for three lanes, one per cycle.
// Depends on edvf_pkg.
module edvf_stepper #(
  parameter int SAMPLE_STEPS = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  edvf_pkg::lane_t [2:0] from_i,
  input  edvf_pkg::lane_t [2:0] to_i,
  output edvf_pkg::smp_t        smp_o
);
  import edvf_pkg::*;

  localparam int IW = $clog2(SAMPLE_STEPS + 1);
  localparam int RW = $clog2(2 * SAMPLE_STEPS);
  localparam logic [17:0]   Recip   = 18'((1 << 17) / SAMPLE_STEPS);
  localparam logic [IW-1:0] LastIdx = IW'(SAMPLE_STEPS);
  localparam logic [RW-1:0] StepsR  = RW'(SAMPLE_STEPS);
  localparam logic [RW:0]   StepsS  = (RW + 1)'(SAMPLE_STEPS);

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_MUL  = 3'd1;
  localparam logic [2:0] P_QUO  = 3'd2;
  localparam logic [2:0] P_FIX  = 3'd3;
  localparam logic [2:0] P_RUN  = 3'd4;

  logic [2:0]       phase_q, phase_d;
  logic [IW-1:0]    idx_q;
  logic             smp_valid_q, smp_last_q;
  lane_t [2:0]      smp_val_q;
  lane_t            base_q [3];
  logic [2:0]       neg_q;
  logic [16:0]      mag_q  [3];
  logic [34:0]      prod_q [3];
  logic [16:0]      qe_q   [3];
  logic [RW-1:0]    re_q   [3];
  logic [16:0]      dq_q   [3];
  logic [RW-1:0]    dr_q   [3];
  logic [16:0]      acc_q  [3];
  logic [RW-1:0]    rem_q  [3];

  logic signed [17:0] diff_w [3];
  logic [17:0]        re_w   [3];
  logic [RW:0]        sum_w  [3];
  logic signed [17:0] off_w  [3];
  logic signed [17:0] val_w  [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      diff_w[l] = 18'(to_i[l]) - 18'(from_i[l]);
      re_w[l]   = 18'(mag_q[l]) - 18'(32'(prod_q[l][33:17]) * SAMPLE_STEPS);
      sum_w[l]  = {1'b0, rem_q[l]} + {1'b0, dr_q[l]};
      off_w[l]  = neg_q[l] ? -$signed({1'b0, acc_q[l]}) : $signed({1'b0, acc_q[l]});
      val_w[l]  = 18'(base_q[l]) + off_w[l];
    end
  end

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      P_IDLE: if (start_i) phase_d = P_MUL;
      P_MUL:  phase_d = P_QUO;
      P_QUO:  phase_d = P_FIX;
      P_FIX:  phase_d = P_RUN;
      P_RUN:  if (idx_q == LastIdx) phase_d = P_IDLE;
      default: phase_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= P_IDLE;
      smp_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      smp_valid_q <= (phase_q == P_RUN);
    end
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      P_IDLE: begin
        for (int l = 0; l < 3; l++) begin
          base_q[l] <= from_i[l];
          neg_q[l]  <= diff_w[l][17];
          mag_q[l]  <= diff_w[l][17] ? 17'(-diff_w[l]) : 17'(diff_w[l]);
        end
      end
      P_MUL: begin
        for (int l = 0; l < 3; l++) begin
          prod_q[l] <= 35'(mag_q[l]) * 35'(Recip);
        end
      end
      P_QUO: begin
        for (int l = 0; l < 3; l++) begin
          qe_q[l] <= prod_q[l][33:17];
          re_q[l] <= RW'(re_w[l]);
        end
      end
      P_FIX: begin
        idx_q <= '0;
        for (int l = 0; l < 3; l++) begin
          if (re_q[l] >= StepsR) begin
            dq_q[l] <= qe_q[l] + 17'd1;
            dr_q[l] <= re_q[l] - StepsR;
          end else begin
            dq_q[l] <= qe_q[l];
            dr_q[l] <= re_q[l];
          end
          acc_q[l] <= '0;
          rem_q[l] <= '0;
        end
      end
      P_RUN: begin
        idx_q      <= idx_q + IW'(1);
        smp_last_q <= (idx_q == LastIdx);
        for (int l = 0; l < 3; l++) begin
          smp_val_q[l] <= val_w[l][16:0];
          if (sum_w[l] >= StepsS) begin
            rem_q[l] <= RW'(sum_w[l] - StepsS);
            acc_q[l] <= acc_q[l] + dq_q[l] + 17'd1;
          end else begin
            rem_q[l] <= RW'(sum_w[l]);
            acc_q[l] <= acc_q[l] + dq_q[l];
          end
        end
      end
      default: begin
        smp_last_q <= 1'b0;
      end
    endcase
  end

  assign smp_o.valid = smp_valid_q;
  assign smp_o.last  = smp_last_q;
  assign smp_o.val   = smp_val_q;

endmodule

// ===== src/edge_depth_visibility_filter_unit.sv =====
// Edge visibility filter against a sampled depth buffer; uses edvf_pkg, edvf_if, edvf_ram, edvf_stepper.
// Write beats are taken whenever the unit is idle. An edge test holds ready low until its result
// is loaded into the output register: two vertex reads, a step division in the stepper (multiply,
// quotient and fix stages), then one depth memory read per sample. Bad index skips the vertex reads;
// both ends off screen skip the sampling. A stalled result register delays the return to idle.
// Reset (async, active low) clears control and loads register defaults; memories are not cleared.
module edge_depth_visibility_filter_unit #(
  parameter int SAMPLE_STEPS = 20,
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int VERTEX_DEPTH = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [edvf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [edvf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  edvf_in_if.sink                         item_i,
  edvf_out_if.source                      result_o
);
  import edvf_pkg::*;

  localparam int DepthEntries = MAX_WIDTH * MAX_HEIGHT;
  localparam int DAW = (DepthEntries > 1) ? $clog2(DepthEntries) : 1;
  localparam int VAW = $clog2(VERTEX_DEPTH);
  localparam int EW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int VCW = $clog2(VERTEX_DEPTH + 1);
  localparam int CW  = $clog2(SAMPLE_STEPS + 2);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RDB  = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_SAMP = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [8:0]  scr_w_q, scr_h_q, vcnt_q;
  logic [15:0] eps_q;
  logic [4:0]  minvis_q;

  logic [EW-1:0]  effw;
  logic [HW-1:0]  effh;
  logic [VCW-1:0] vc;

  logic accept, idx_bad, is_test;

  logic           dwe, dre;
  logic [DAW-1:0] dwaddr, draddr;
  logic [15:0]    drdata;
  logic           vwe, vre;
  logic [VAW-1:0] vwaddr, vraddr;
  logic [47:0]    vrdata;

  logic [9:0]  b_q;
  logic [47:0] va_q;
  logic signed [15:0] ax, ay, bx, by;
  logic [15:0] az, bz;
  logic        on_a, on_b;

  logic        step_start;
  lane_t [2:0] from_w, to_w;
  smp_t        smp;

  lane_t              sx, sy;
  logic signed [18:0] x_lim, y_lim;
  logic               inb_x, inb_y;
  logic [12:0]        px_n, py_n;
  logic               p_valid_q, p_last_q, p_inb_q;
  logic [15:0]        p_z_q;
  logic               vis;
  logic [CW-1:0]      count_q, count_d;

  logic [1:0]         status_q;
  logic signed [15:0] lx1_q, ly1_q, lx2_q, ly2_q;

  logic               out_valid_q, out_load;
  logic [1:0]         out_status_q;
  logic [4:0]         out_count_q;
  logic signed [15:0] out_x1_q, out_y1_q, out_x2_q, out_y2_q;

  function automatic logic onscr(input logic signed [15:0] x, input logic signed [15:0] y,
                                 input logic [EW-1:0] w, input logic [HW-1:0] h);
    onscr = !x[15] && ({1'b0, x} < 17'({w, 4'b0000})) &&
            !y[15] && ({1'b0, y} < 17'({h, 4'b0000}));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q  <= SCREEN_WIDTH_RST;
      scr_h_q  <= SCREEN_HEIGHT_RST;
      vcnt_q   <= VERTEX_COUNT_RST;
      eps_q    <= DEPTH_EPSILON_RST;
      minvis_q <= MIN_VISIBLE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SCREEN_WIDTH:  scr_w_q  <= cfg_data_i[8:0];
        CFG_SCREEN_HEIGHT: scr_h_q  <= cfg_data_i[8:0];
        CFG_VERTEX_COUNT:  vcnt_q   <= cfg_data_i[8:0];
        CFG_DEPTH_EPSILON: eps_q    <= cfg_data_i;
        CFG_MIN_VISIBLE:   minvis_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign effw = (32'(scr_w_q) > MAX_WIDTH) ? EW'(MAX_WIDTH) : EW'(scr_w_q);
  assign effh = (32'(scr_h_q) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(scr_h_q);
  assign vc   = (32'(vcnt_q) > VERTEX_DEPTH) ? VCW'(VERTEX_DEPTH) : VCW'(vcnt_q);

  assign item_i.ready = (state_q == ST_IDLE);
  assign accept       = item_i.valid && item_i.ready;
  assign is_test      = accept && (item_i.opcode == OP_TEST_EDGE);
  assign idx_bad      = (32'(item_i.edge_first) >= 32'(vc)) ||
                        (32'(item_i.edge_second) >= 32'(vc));

  assign vwe    = accept && (item_i.opcode == OP_WRITE_VERTEX) &&
                  (32'(item_i.vert_slot) < VERTEX_DEPTH);
  assign vwaddr = VAW'(item_i.vert_slot);
  assign vre    = (is_test && !idx_bad) || (state_q == ST_RDB);
  assign vraddr = (state_q == ST_RDB) ? VAW'(b_q) : VAW'(item_i.edge_first);

  edvf_ram #(.Width(48), .Depth(VERTEX_DEPTH)) u_vtx_ram (
    .clk_i   (clk_i),
    .we_i    (vwe),
    .waddr_i (vwaddr),
    .wdata_i ({item_i.vert_x, item_i.vert_y, item_i.vert_z}),
    .re_i    (vre),
    .raddr_i (vraddr),
    .rdata_o (vrdata)
  );

  assign ax = signed'(va_q[47:32]);
  assign ay = signed'(va_q[31:16]);
  assign az = va_q[15:0];
  assign bx = signed'(vrdata[47:32]);
  assign by = signed'(vrdata[31:16]);
  assign bz = vrdata[15:0];
  assign on_a = onscr(ax, ay, effw, effh);
  assign on_b = onscr(bx, by, effw, effh);

  assign step_start     = (state_q == ST_CHK) && (on_a || on_b);
  assign from_w[LANE_X] = 17'(ax);
  assign from_w[LANE_Y] = 17'(ay);
  assign from_w[LANE_Z] = signed'({1'b0, az});
  assign to_w[LANE_X]   = 17'(bx);
  assign to_w[LANE_Y]   = 17'(by);
  assign to_w[LANE_Z]   = signed'({1'b0, bz});

  edvf_stepper #(.SAMPLE_STEPS(SAMPLE_STEPS)) u_stepper (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (step_start),
    .from_i  (from_w),
    .to_i    (to_w),
    .smp_o   (smp)
  );

  assign sx    = smp.val[LANE_X];
  assign sy    = smp.val[LANE_Y];
  assign x_lim = signed'(19'({effw, 4'b0000}));
  assign y_lim = signed'(19'({effh, 4'b0000}));
  assign inb_x = (effw != '0) && (sx >= -17'sd15) && (19'(sx) < x_lim);
  assign inb_y = (effh != '0) && (sy >= -17'sd15) && (19'(sy) < y_lim);
  assign px_n  = sx[16] ? 13'd0 : sx[16:4];
  assign py_n  = sy[16] ? 13'd0 : sy[16:4];

  assign dwe    = accept && (item_i.opcode == OP_WRITE_DEPTH) &&
                  (32'(item_i.pixel_x) < MAX_WIDTH) && (32'(item_i.pixel_y) < MAX_HEIGHT);
  assign dwaddr = DAW'(item_i.pixel_x) + DAW'(DAW'(item_i.pixel_y) * DAW'(MAX_WIDTH));
  assign dre    = smp.valid && inb_x && inb_y;
  assign draddr = DAW'(px_n) + DAW'(DAW'(py_n) * DAW'(MAX_WIDTH));

  edvf_ram #(.Width(16), .Depth(DepthEntries)) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (dwe),
    .waddr_i (dwaddr),
    .wdata_i (item_i.pixel_depth),
    .re_i    (dre),
    .raddr_i (draddr),
    .rdata_o (drdata)
  );

  assign vis     = p_inb_q && (17'(p_z_q) <= (17'(drdata) + 17'(eps_q)));
  assign count_d = count_q + CW'(vis);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (is_test) begin
          state_d = idx_bad ? ST_EMIT : ST_RDB;
        end
      end
      ST_RDB:  state_d = ST_CHK;
      ST_CHK:  state_d = (on_a || on_b) ? ST_SAMP : ST_EMIT;
      ST_SAMP: if (p_valid_q && p_last_q) state_d = ST_EMIT;
      ST_EMIT: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      p_valid_q <= smp.valid;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_last_q <= smp.last;
    p_inb_q  <= inb_x && inb_y;
    p_z_q    <= smp.val[LANE_Z][15:0];
    case (state_q)
      ST_IDLE: begin
        b_q      <= item_i.edge_second;
        status_q <= STATUS_BAD_INDEX;
        count_q  <= '0;
        lx1_q    <= '0;
        ly1_q    <= '0;
        lx2_q    <= '0;
        ly2_q    <= '0;
      end
      ST_RDB: begin
        va_q <= vrdata;
      end
      ST_CHK: begin
        status_q <= STATUS_OFF_SCREEN;
        lx1_q    <= ax;
        ly1_q    <= ay;
        lx2_q    <= bx;
        ly2_q    <= by;
      end
      ST_SAMP: begin
        if (p_valid_q) begin
          count_q  <= count_d;
          status_q <= (32'(count_d) >= 32'(minvis_q)) ? STATUS_VISIBLE : STATUS_HIDDEN;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_status_q <= status_q;
      out_count_q  <= 5'(count_q);
      out_x1_q     <= lx1_q;
      out_y1_q     <= ly1_q;
      out_x2_q     <= lx2_q;
      out_y2_q     <= ly2_q;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.status          = out_status_q;
  assign result_o.visible_samples = out_count_q;
  assign result_o.line_x1         = out_x1_q;
  assign result_o.line_y1         = out_y1_q;
  assign result_o.line_x2         = out_x2_q;
  assign result_o.line_y2         = out_y2_q;

endmodule

// ===== src/edvf_checker.sv =====
// Port-level checks of the edge depth visibility filter, bound to the top level.
// Depends on edvf_pkg and edge_depth_visibility_filter_unit.
module edvf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic [1:0]         in_opcode_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [1:0]         out_status_i,
  input logic [4:0]         out_count_i,
  input logic signed [15:0] out_x1_i,
  input logic signed [15:0] out_y1_i,
  input logic signed [15:0] out_x2_i,
  input logic signed [15:0] out_y2_i
);
  import edvf_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i) &&
      $stable(out_count_i) && $stable(out_x1_i) && $stable(out_y1_i) &&
      $stable(out_x2_i) && $stable(out_y2_i))
    else $error("result beat dropped or changed while stalled");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == STATUS_BAD_INDEX) |->
      (out_count_i == 5'd0) && (out_x1_i == 16'sd0) && (out_y1_i == 16'sd0) &&
      (out_x2_i == 16'sd0) && (out_y2_i == 16'sd0))
    else $error("bad index result carries nonzero data");

  a_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == STATUS_OFF_SCREEN) |-> (out_count_i == 5'd0))
    else $error("off-screen result carries a sample count");

  a_test_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_opcode_i == OP_TEST_EDGE) |=> !in_ready_i)
    else $error("new beat taken while an edge test is in progress");

endmodule

bind edge_depth_visibility_filter_unit edvf_checker u_edvf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (item_i.valid),
  .in_ready_i   (item_i.ready),
  .in_opcode_i  (item_i.opcode),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_status_i (result_o.status),
  .out_count_i  (result_o.visible_samples),
  .out_x1_i     (result_o.line_x1),
  .out_y1_i     (result_o.line_y1),
  .out_x2_i     (result_o.line_x2),
  .out_y2_i     (result_o.line_y2)
);

// ===== verif/edge_depth_visibility_filter_unit_tb.sv =====
// Self-checking bench for edge_depth_visibility_filter_unit: loads depth pixels and vertices,
// tests edges and checks every verdict beat against its own visibility predictor.
// Depends on edvf_pkg, edvf_in_if / edvf_out_if and the unit itself.
module edge_depth_visibility_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import edvf_pkg::*;

  localparam int          STEPS         = 20;
  localparam int          ROW_PITCH     = 256;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          PHASE_ITEMS   = 150;
  localparam int          ITEM_TARGET   = 1550;
  localparam int          MIN_VERDICTS  = 48;
  localparam int          LIMIT_CYCLES  = 600000;
  localparam logic [1:0]  OP_RESERVED   = 2'd3;

  typedef struct {
    logic [1:0]         op;
    logic [7:0]         px;
    logic [7:0]         py;
    logic [15:0]        pdepth;
    logic [7:0]         slot;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic [15:0]        vz;
    logic [9:0]         ea;
    logic [9:0]         eb;
  } req_t;

  typedef struct {
    logic [1:0]         status;
    logic [4:0]         vis;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic signed [15:0] x2;
    logic signed [15:0] y2;
  } verdict_t;

  class visibility_scoreboard;
    logic [15:0]        depth_mem [65536];
    logic signed [15:0] vtx_x [256];
    logic signed [15:0] vtx_y [256];
    logic [15:0]        vtx_z [256];
    logic [8:0]         scr_w;
    logic [8:0]         scr_h;
    logic [8:0]         vtx_cnt;
    logic [15:0]        eps;
    logic [4:0]         min_vis;
    verdict_t           pending_verdicts [$];
    int unsigned        mismatches;
    int unsigned        verdicts_seen;
    int unsigned        verdict_tally [4];

    function new();
      scr_w         = SCREEN_WIDTH_RST;
      scr_h         = SCREEN_HEIGHT_RST;
      vtx_cnt       = VERTEX_COUNT_RST;
      eps           = DEPTH_EPSILON_RST;
      min_vis       = MIN_VISIBLE_RST;
      mismatches    = 0;
      verdicts_seen = 0;
      verdict_tally = '{default: 0};
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SCREEN_WIDTH:  scr_w   = data[8:0];
        CFG_SCREEN_HEIGHT: scr_h   = data[8:0];
        CFG_VERTEX_COUNT:  vtx_cnt = data[8:0];
        CFG_DEPTH_EPSILON: eps     = data;
        CFG_MIN_VISIBLE:   min_vis = data[4:0];
        default: ;
      endcase
    endfunction

    function int usable_width();
      return (scr_w > 256) ? 256 : int'(scr_w);
    endfunction

    function int usable_height();
      return (scr_h > 256) ? 256 : int'(scr_h);
    endfunction

    function int usable_vertices();
      return (vtx_cnt > 256) ? 256 : int'(vtx_cnt);
    endfunction

    function bit on_screen(longint x, longint y);
      return x >= 0 && x < usable_width() * 16 && y >= 0 && y < usable_height() * 16;
    endfunction

    function longint lerp(longint p, longint q, int i);
      return p + (i * (q - p)) / STEPS;
    endfunction

    // Depth addresses and depths of the samples that land on screen.
    function void trace_edge(int a, int b, output int addrs[$], output longint zs[$]);
      longint sx, sy, sz, px, py;
      int     i;
      addrs.delete();
      zs.delete();
      for (i = 0; i <= STEPS; i++) begin
        sx = lerp(vtx_x[a], vtx_x[b], i);
        sy = lerp(vtx_y[a], vtx_y[b], i);
        sz = lerp(longint'(vtx_z[a]), longint'(vtx_z[b]), i);
        px = sx / 16;
        py = sy / 16;
        if (px >= 0 && px < usable_width() && py >= 0 && py < usable_height()) begin
          addrs = {addrs, int'(px + py * ROW_PITCH)};
          zs = {zs, sz};
        end
      end
    endfunction

    function verdict_t judge_edge(req_t r);
      verdict_t v;
      int       a, b, k, count;
      int       addrs [$];
      longint   zs [$];
      a = int'(r.ea);
      b = int'(r.eb);
      v.status = STATUS_BAD_INDEX;
      v.vis = '0;
      v.x1 = '0;
      v.y1 = '0;
      v.x2 = '0;
      v.y2 = '0;
      if (a >= usable_vertices() || b >= usable_vertices()) return v;
      v.x1 = vtx_x[a];
      v.y1 = vtx_y[a];
      v.x2 = vtx_x[b];
      v.y2 = vtx_y[b];
      if (!on_screen(vtx_x[a], vtx_y[a]) && !on_screen(vtx_x[b], vtx_y[b])) begin
        v.status = STATUS_OFF_SCREEN;
        return v;
      end
      trace_edge(a, b, addrs, zs);
      count = 0;
      for (k = 0; k < addrs.size(); k++)
        if (zs[k] <= longint'(depth_mem[addrs[k]]) + longint'(eps)) count++;
      v.vis = 5'(count);
      v.status = (count >= int'(min_vis)) ? STATUS_VISIBLE : STATUS_HIDDEN;
      return v;
    endfunction

    function void note_request(req_t r);
      case (r.op)
        OP_WRITE_DEPTH:  depth_mem[{r.py, r.px}] = r.pdepth;
        OP_WRITE_VERTEX: begin
          vtx_x[r.slot] = r.vx;
          vtx_y[r.slot] = r.vy;
          vtx_z[r.slot] = r.vz;
        end
        OP_TEST_EDGE:    pending_verdicts.insert(pending_verdicts.size(), judge_edge(r));
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic signed [16:0] want,
                                logic signed [16:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      verdicts_seen++;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected verdict, expected none, got status %0d count %0d",
                 $time, got.status, got.vis);
        mismatches++;
        return;
      end
      want = pending_verdicts.pop_front();
      verdict_tally[want.status]++;
      compare_field("status", want.status, got.status);
      compare_field("visible_samples", want.vis, got.vis);
      compare_field("line_x1", want.x1, got.x1);
      compare_field("line_y1", want.y1, got.y1);
      compare_field("line_x2", want.x2, got.x2);
      compare_field("line_y2", want.y2, got.y2);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  edvf_in_if  req_if ();
  edvf_out_if res_if ();

  edge_depth_visibility_filter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .item_i      (req_if),
    .result_o    (res_if)
  );

  visibility_scoreboard sb = new();

  bit          depth_written [65536];
  bit          vert_written [256];
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  int unsigned rx_hold_pending = 0;
  int unsigned items_sent = 0;

  always #4 clk_i = ~clk_i;

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d verdicts still pending",
             LIMIT_CYCLES, sb.pending_verdicts.size());
    $display("[edge_depth_visibility_filter_unit] ERROR");
    $finish;
  end

  function automatic int unsigned draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic req_t blank_req(logic [1:0] op);
    req_t r;
    r.op     = op;
    r.px     = 8'($urandom);
    r.py     = 8'($urandom);
    r.pdepth = 16'($urandom);
    r.slot   = 8'($urandom);
    r.vx     = 16'($urandom);
    r.vy     = 16'($urandom);
    r.vz     = 16'($urandom);
    r.ea     = 10'($urandom);
    r.eb     = 10'($urandom);
    return r;
  endfunction

  function automatic int rand_coord(int cells);
    int span, v;
    span = ((cells < 1) ? 1 : cells) * 16;
    case ($urandom_range(0, 9))
      0:       v = int'($urandom);
      1, 2:    v = int'($urandom_range(0, 2 * span)) - span / 2;
      default: v = int'($urandom_range(0, span - 1));
    endcase
    return int'(16'(v));
  endfunction

  function automatic int near_depth(longint z);
    longint d;
    case ($urandom_range(0, 7))
      0:       d = 0;
      1:       d = 65535;
      2:       d = longint'($urandom_range(0, 65535));
      default: d = z + longint'($urandom_range(0, 96)) - 48;
    endcase
    if (d < 0) d = 0;
    if (d > 65535) d = 65535;
    return int'(d);
  endfunction

  function automatic int pick_slot(int vc);
    if ($urandom_range(0, 9) < 7) return int'($urandom_range(0, ((vc < 24) ? vc : 24) - 1));
    return int'($urandom_range(0, vc - 1));
  endfunction

  function automatic int pick_pixel(int n);
    if (n < 1 || $urandom_range(0, 3) == 0) return int'($urandom_range(0, 255));
    return int'($urandom_range(0, n - 1));
  endfunction

  function automatic int pick_extent();
    int r;
    r = int'($urandom_range(0, 9));
    if (r < 6) return 256;
    if (r < 8) return int'($urandom_range(1, 256));
    if (r < 9) return 1;
    return int'($urandom_range(1, 16));
  endfunction

  // Leaves valid high on return; the caller drives the next beat or drops valid in the same step.
  task automatic send_item(req_t r);
    int unsigned gap;
    gap = draw_gap(tx_burst);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.opcode      <= r.op;
    req_if.pixel_x     <= r.px;
    req_if.pixel_y     <= r.py;
    req_if.pixel_depth <= r.pdepth;
    req_if.vert_slot   <= r.slot;
    req_if.vert_x      <= r.vx;
    req_if.vert_y      <= r.vy;
    req_if.vert_z      <= r.vz;
    req_if.edge_first  <= r.ea;
    req_if.edge_second <= r.eb;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(r);
    if (r.op == OP_WRITE_DEPTH) depth_written[{r.py, r.px}] = 1'b1;
    if (r.op == OP_WRITE_VERTEX) vert_written[r.slot] = 1'b1;
    if (r.op != OP_RESERVED) items_sent++;
  endtask

  task automatic write_depth(int x, int y, int d);
    req_t r;
    r = blank_req(OP_WRITE_DEPTH);
    r.px = 8'(x);
    r.py = 8'(y);
    r.pdepth = 16'(d);
    send_item(r);
  endtask

  task automatic write_vertex(int slot, int x, int y, int z);
    req_t r;
    r = blank_req(OP_WRITE_VERTEX);
    r.slot = 8'(slot);
    r.vx = 16'(x);
    r.vy = 16'(y);
    r.vz = 16'(z);
    send_item(r);
  endtask

  task automatic test_edge(int a, int b);
    req_t r;
    r = blank_req(OP_TEST_EDGE);
    r.ea = 10'(a);
    r.eb = 10'(b);
    send_item(r);
  endtask

  task automatic ensure_vertex(int idx);
    if (idx < sb.usable_vertices() && !vert_written[idx])
      write_vertex(idx, rand_coord(sb.usable_width()), rand_coord(sb.usable_height()),
                   int'($urandom_range(0, 65535)));
  endtask

  // Load both endpoints and every depth pixel the edge will sample.
  task automatic prepare_edge(int a, int b);
    int     addrs [$];
    longint zs [$];
    int     k;
    ensure_vertex(a);
    ensure_vertex(b);
    if (a < sb.usable_vertices() && b < sb.usable_vertices()) begin
      sb.trace_edge(a, b, addrs, zs);
      for (k = 0; k < addrs.size(); k++)
        if (!depth_written[addrs[k]])
          write_depth(addrs[k] % ROW_PITCH, addrs[k] / ROW_PITCH, near_depth(zs[k]));
    end
  endtask

  task automatic check_edge(int a, int b);
    prepare_edge(a, b);
    test_edge(a, b);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_config(int w, int h, int vc, int eps, int mv);
    logic [CFG_IDX_W-1:0]  idxs [5];
    logic [CFG_DATA_W-1:0] vals [5];
    int                    k;
    idxs = '{CFG_SCREEN_WIDTH, CFG_SCREEN_HEIGHT, CFG_VERTEX_COUNT, CFG_DEPTH_EPSILON,
             CFG_MIN_VISIBLE};
    vals = '{16'(w), 16'(h), 16'(vc), 16'(eps), 16'(mv)};
    drain();
    for (k = 0; k < 5; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idxs[k];
      cfg_data  <= vals[k];
      @(posedge clk_i);
      sb.set_reg(idxs[k], vals[k]);
    end
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic directed_phase();
    check_edge(0, 0);
    check_edge(1023, 1023);
    apply_config(256, 256, 256, 0, 11);
    write_vertex(0, 0, 0, 0);
    write_vertex(1, 4095, 4095, 65535);
    write_vertex(2, -32768, -32768, 0);
    write_vertex(3, 32767, 32767, 65535);
    write_vertex(4, -8, -8, 100);
    write_depth(0, 0, 0);
    write_depth(255, 255, 65535);
    check_edge(0, 1);
    check_edge(2, 3);
    check_edge(0, 2);
    check_edge(4, 0);
    check_edge(1, 1);
    check_edge(255, 1023);
    check_edge(1023, 0);
    send_item(blank_req(OP_RESERVED));
    apply_config(256, 256, 256, 65535, 21);
    check_edge(0, 1);
    apply_config(256, 256, 256, 0, 31);
    check_edge(0, 1);
    apply_config(256, 256, 256, 0, 0);
    check_edge(0, 2);
    apply_config(0, 0, 256, 0, 11);
    check_edge(0, 1);
    apply_config(511, 300, 511, 100, 11);
    check_edge(0, 1);
    check_edge(0, 300);
  endtask

  // Stall the result side while tests arrive back to back.
  task automatic pressure_phase();
    int firsts [20];
    int seconds [20];
    int n;
    apply_config(256, 256, 32, 16, 6);
    for (n = 0; n < 20; n++) begin
      firsts[n] = pick_slot(32);
      seconds[n] = pick_slot(32);
      prepare_edge(firsts[n], seconds[n]);
    end
    tx_burst = 1'b1;
    rx_hold_pending = HOLD_CYCLES;
    for (n = 0; n < 20; n++) test_edge(firsts[n], seconds[n]);
    tx_burst = 1'b0;
  endtask

  task automatic random_step();
    int vc, r, a, b;
    vc = sb.usable_vertices();
    r = int'($urandom_range(0, 19));
    if (r < 10) begin
      if (vc > 0) check_edge(pick_slot(vc), pick_slot(vc));
      else check_edge(int'($urandom_range(0, 1023)), int'($urandom_range(0, 1023)));
    end else if (r < 12) begin
      a = (vc > 0) ? pick_slot(vc) : int'($urandom_range(0, 1023));
      b = int'($urandom_range(vc, 1023));
      if ($urandom_range(0, 1) == 0) check_edge(a, b);
      else check_edge(b, a);
    end else if (r < 15) begin
      a = ($urandom_range(0, 1) == 0) ? pick_slot((vc > 0) ? vc : 256)
                                      : int'($urandom_range(0, 255));
      write_vertex(a, rand_coord(sb.usable_width()), rand_coord(sb.usable_height()),
                   int'($urandom_range(0, 65535)));
    end else if (r < 19) begin
      write_depth(pick_pixel(sb.usable_width()), pick_pixel(sb.usable_height()),
                  near_depth(longint'($urandom_range(0, 65535))));
    end else begin
      send_item(blank_req(OP_RESERVED));
    end
  endtask

  task automatic random_phase();
    int w, h, vc, eps, mv, r, target;
    w = pick_extent();
    h = pick_extent();
    r = int'($urandom_range(0, 9));
    vc = (r < 5) ? 256 : (r < 9) ? int'($urandom_range(1, 64)) : int'($urandom_range(0, 256));
    r = int'($urandom_range(0, 9));
    eps = (r < 4) ? 0 : (r < 7) ? int'($urandom_range(0, 64)) :
          (r < 8) ? 65535 : int'($urandom_range(0, 65535));
    r = int'($urandom_range(0, 9));
    mv = (r < 1) ? 0 : (r < 2) ? 21 : int'($urandom_range(1, 20));
    apply_config(w, h, vc, eps, mv);
    tx_burst = ($urandom_range(0, 3) == 0);
    rx_burst = ($urandom_range(0, 3) == 0);
    target = int'(items_sent) + PHASE_ITEMS;
    while (int'(items_sent) < target) random_step();
  endtask

  initial begin
    verdict_t    got;
    int unsigned rx_wait;
    int unsigned rx_hold;
    rx_wait = 0;
    rx_hold = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        got.status = res_if.status;
        got.vis    = res_if.visible_samples;
        got.x1     = res_if.line_x1;
        got.y1     = res_if.line_y1;
        got.x2     = res_if.line_x2;
        got.y2     = res_if.line_y2;
        sb.check_verdict(got);
        rx_wait = draw_gap(rx_burst);
      end
      if (rx_hold_pending != 0) begin
        rx_hold = rx_hold_pending;
        rx_hold_pending = 0;
      end
      if (rx_hold != 0) begin
        rx_hold--;
        res_if.ready <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    req_if.valid       = 1'b0;
    req_if.opcode      = OP_WRITE_DEPTH;
    req_if.pixel_x     = '0;
    req_if.pixel_y     = '0;
    req_if.pixel_depth = '0;
    req_if.vert_slot   = '0;
    req_if.vert_x      = '0;
    req_if.vert_y      = '0;
    req_if.vert_z      = '0;
    req_if.edge_first  = '0;
    req_if.edge_second = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_phase();
    pressure_phase();
    while (items_sent < ITEM_TARGET || sb.verdicts_seen < MIN_VERDICTS) random_phase();
    drain();

    $display("covered %0d request beats and %0d verdicts across screen, threshold and tolerance",
             items_sent, sb.verdicts_seen);
    $display("verdicts: %0d visible, %0d hidden, %0d bad index, %0d off screen",
             sb.verdict_tally[STATUS_VISIBLE], sb.verdict_tally[STATUS_HIDDEN],
             sb.verdict_tally[STATUS_BAD_INDEX], sb.verdict_tally[STATUS_OFF_SCREEN]);
    if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0) begin
      $display("[edge_depth_visibility_filter_unit] OK");
    end else begin
      $display("[edge_depth_visibility_filter_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/edvf_pkg.sv
src/edvf_if.sv
src/edvf_ram.sv
src/edvf_stepper.sv
src/edge_depth_visibility_filter_unit.sv
src/edvf_checker.sv
verif/edge_depth_visibility_filter_unit_tb.sv
